// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/fpfc_pkg.sv
// Types and constants of the fractional PLL factor calculator.
`default_nettype none
package fpfc_pkg;
  localparam int FRAC_BITS_DEF = 24;
  localparam int DIV_W = 32;
  localparam logic [31:0] N_MIN = 32'd6;
  localparam logic [31:0] N_MAX = 32'd12;
  localparam logic [4:0] ROUND_HALF = 5'd5;
  // ceil(2^31 / 10); exact quotient by ten for values below 2^30
  localparam logic [27:0] RECIP10 = 28'd214748365;
  localparam int RECIP_SHIFT = 31;

  typedef struct packed {
    logic [31:0] target_freq;
    logic [31:0] ref_freq;
  } req_t;

  typedef struct packed {
    logic        prescale_half;
    logic [3:0]  int_ratio;
    logic [23:0] frac_ratio;
    logic        ratio_out_of_range;
    logic        ref_zero_error;
  } res_t;

  typedef struct packed {
    logic        valid;
    logic        pre;
    logic        zero;
    logic [31:0] d;
    logic [31:0] p;
    logic [31:0] dvd;
    logic [31:0] q;
    logic [31:0] n;
  } stage_t;
endpackage
`default_nettype wire

// File: hw/rtl/fpfc_div_cell.sv
// One restoring-division step with its stage register.
`default_nettype none
module fpfc_div_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire fpfc_pkg::stage_t prev,
  output fpfc_pkg::stage_t     cur
);
  import fpfc_pkg::*;

  logic [32:0] t;
  logic [32:0] diff;
  logic        ge;
  stage_t      nxt;

  always_comb begin
    t    = {prev.p, prev.dvd[31]};
    diff = t - {1'b0, prev.d};
    ge   = (t >= {1'b0, prev.d});
    nxt  = prev;
    nxt.p   = ge ? diff[31:0] : t[31:0];
    nxt.dvd = {prev.dvd[30:0], 1'b0};
    nxt.q   = {prev.q[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur <= nxt;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/fractional_pll_factor_calc.sv
// Top level of the fractional PLL factor calculator.
// Usage:
//   A request (target_freq, ref_freq) enters on req_valid/req_ready; one result
//   (prescale flag, integer ratio N, fraction K, range and zero flags) leaves on
//   res_valid/res_ready for every request, in order.
//   Throughput is one request per cycle while the output queue is not full.
//   From acceptance to res_valid a request passes one setup stage, 32 cells
//   forming N and the remainder, one stage scaling the remainder by ten,
//   FRAC_BITS + 4 cells forming the unrounded fraction, one multiply stage
//   for the divide by ten, and a two-entry output queue. Each division cell
//   retires one quotient bit. A zero divisor (reference zero, or one that
//   halves to zero) gives an error flag and zero factors.
//   Reset empties the pipeline and the output queue.
//   When the receiver stalls, the queue fills; once it holds two results the
//   whole pipeline freezes and req_ready drops until a result is taken.
`default_nettype none
module fractional_pll_factor_calc #(
  parameter int FRAC_BITS = fpfc_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire fpfc_pkg::req_t req_data,
  output logic               res_valid,
  input  wire logic          res_ready,
  output fpfc_pkg::res_t     res_data
);
  import fpfc_pkg::*;
  `include "assert_macros.svh"

  localparam int QW = FRAC_BITS + 4;
  localparam int VW = QW + 1;
  localparam int PW = VW + 28;

  logic   en;
  stage_t s0;
  stage_t s0_next;
  stage_t c1 [0:DIV_W];
  stage_t xf;
  stage_t xf_next;
  stage_t c2 [0:QW];
  logic [34:0] ref6;
  logic [35:0] p10;

  logic          m_valid;
  logic          m_pre;
  logic          m_zero;
  logic [31:0]   m_n;
  logic [PW-1:0] m_prod;
  logic [VW-1:0] kround;
  res_t          m_res;

  res_t        fifo [0:1];
  logic        rd_ptr;
  logic        wr_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign en        = (count != 2'd2);
  assign req_ready = en;

  always_comb begin
    ref6 = ({3'b0, req_data.ref_freq} << 2) + ({3'b0, req_data.ref_freq} << 1);
    s0_next       = '0;
    s0_next.valid = req_valid;
    s0_next.pre   = (req_data.ref_freq != 32'd0) && ({3'b0, req_data.target_freq} < ref6);
    s0_next.zero  = (req_data.ref_freq == 32'd0) ||
                    (s0_next.pre && (req_data.ref_freq == 32'd1));
    s0_next.d     = s0_next.pre ? (req_data.ref_freq >> 1) : req_data.ref_freq;
    s0_next.dvd   = req_data.target_freq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
    end else if (en) begin
      s0 <= s0_next;
    end
  end

  assign c1[0] = s0;

  for (genvar i = 0; i < DIV_W; i++) begin : g_int
    fpfc_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .prev(c1[i]),
      .cur (c1[i+1])
    );
  end

  always_comb begin
    p10 = ({4'b0, c1[DIV_W].p} << 3) + ({4'b0, c1[DIV_W].p} << 1);
    xf_next     = c1[DIV_W];
    xf_next.n   = c1[DIV_W].q;
    xf_next.p   = p10[35:4];
    xf_next.dvd = {p10[3:0], 28'd0};
    xf_next.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xf.valid <= 1'b0;
    end else if (en) begin
      xf <= xf_next;
    end
  end

  assign c2[0] = xf;

  for (genvar j = 0; j < QW; j++) begin : g_frac
    fpfc_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .prev(c2[j]),
      .cur (c2[j+1])
    );
  end

  assign kround = {1'b0, c2[QW].q[QW-1:0]} + VW'(ROUND_HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= c2[QW].valid;
      m_pre   <= c2[QW].pre;
      m_zero  <= c2[QW].zero;
      m_n     <= c2[QW].n;
      m_prod  <= PW'(kround) * PW'(RECIP10);
    end
  end

  always_comb begin
    m_res = '0;
    m_res.ref_zero_error = m_zero;
    if (!m_zero) begin
      m_res.prescale_half      = m_pre;
      m_res.int_ratio          = m_n[3:0];
      m_res.frac_ratio         = 24'(m_prod[RECIP_SHIFT +: FRAC_BITS]);
      m_res.ratio_out_of_range = (m_n < N_MIN) || (m_n > N_MAX);
    end
  end

  assign push      = en && m_valid;
  assign pop       = res_valid && res_ready;
  assign res_valid = (count != 2'd0);
  assign res_data  = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= m_res;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `ASSERT_ALWAYS(a_count_range, clk, rst, count != 2'd3)
  `ASSERT_IMPLIES(a_zero_clean, clk, rst, res_valid && res_data.ref_zero_error,
    res_data.int_ratio == 4'd0 && res_data.frac_ratio == 24'd0 && !res_data.prescale_half)
  `ASSERT_NEXT(a_hold_stall, clk, rst, res_valid && !res_ready, res_valid)
  `ASSERT_IMPLIES(a_full_blocks, clk, rst, count == 2'd2, !req_ready)
endmodule
`default_nettype wire
